### hw/rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the palette color context core
// Item structs, field widths, neighbor weights and the context match table.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int IDX_W         = 3;
  localparam int POS_W         = 6;
  localparam int WIDTH_W       = 7;
  localparam int PSIZE_W       = 4;
  localparam int SCORE_W       = 4;
  localparam int CTX_W         = 14;
  localparam int ORDER_SLOTS   = 8;
  localparam int NB_COUNT      = 4;
  localparam int CONTEXT_COUNT = 16;

  localparam logic [CTX_W-1:0] PACK_BASE = CTX_W'(11);
  localparam logic [CTX_W-1:0] PACK_MAX  = CTX_W'(14640);

  localparam logic [SCORE_W-1:0] NB_WEIGHT [NB_COUNT] = '{
    SCORE_W'(3), SCORE_W'(2), SCORE_W'(3), SCORE_W'(2)
  };

  localparam logic [CTX_W-1:0] CTX_TABLE [CONTEXT_COUNT] = '{
    CTX_W'(3993),  CTX_W'(4235),  CTX_W'(4378),  CTX_W'(4380),
    CTX_W'(5720),  CTX_W'(6655),  CTX_W'(7018),  CTX_W'(7040),
    CTX_W'(7260),  CTX_W'(8228),  CTX_W'(8250),  CTX_W'(8470),
    CTX_W'(9680),  CTX_W'(10648), CTX_W'(10890), CTX_W'(13310)
  };

  typedef logic [ORDER_SLOTS-1:0][IDX_W-1:0] order_t;

  typedef struct packed {
    logic [IDX_W-1:0]   left_index;
    logic [IDX_W-1:0]   above_left_index;
    logic [IDX_W-1:0]   above_index;
    logic [IDX_W-1:0]   above_right_index;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [WIDTH_W-1:0] block_width;
    logic [PSIZE_W-1:0] color_count;
  } in_t;

  typedef struct packed {
    logic [CTX_W-1:0] color_context;
    logic [IDX_W-1:0] order_0;
    logic [IDX_W-1:0] order_1;
    logic [IDX_W-1:0] order_2;
    logic [IDX_W-1:0] order_3;
    logic [IDX_W-1:0] order_4;
    logic [IDX_W-1:0] order_5;
    logic [IDX_W-1:0] order_6;
    logic [IDX_W-1:0] order_7;
  } out_t;

endpackage

`default_nettype wire

### hw/rtl/pcc_front.sv
// ----------------------------------------------------------------------------
// pcc_front: neighbor classification and scoring
// Drops neighbors outside the block, accumulates weighted scores per palette
// index and saturates the search bound, then pushes the result to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_front #(
  parameter int MAX_COLORS = 8,
  parameter int QW         = pcc_pkg::PSIZE_W + MAX_COLORS * pcc_pkg::SCORE_W
) (
  input  wire pcc_pkg::in_t in_data,
  input  wire               in_valid,
  input  wire               q_full,
  output logic              in_stall,
  output logic              push,
  output logic [QW-1:0]     push_data
);

  logic [pcc_pkg::NB_COUNT-1:0]                    use_nb;
  logic [pcc_pkg::IDX_W-1:0]                       nb [pcc_pkg::NB_COUNT];
  logic [MAX_COLORS-1:0][pcc_pkg::SCORE_W-1:0]     score;
  logic [pcc_pkg::PSIZE_W-1:0]                     n_bound;
  logic                                            col_nz;
  logic                                            row_nz;

  always_comb begin
    col_nz = |in_data.col;
    row_nz = |in_data.row;
    use_nb[0] = col_nz;
    use_nb[1] = col_nz && row_nz;
    use_nb[2] = row_nz;
    // above-right exists when col + 1 <= width - 1, i.e. col + 2 <= width
    use_nb[3] = row_nz &&
                (({2'b00, in_data.col} + 8'd2) <= {1'b0, in_data.block_width});
    nb[0] = in_data.left_index;
    nb[1] = in_data.above_left_index;
    nb[2] = in_data.above_index;
    nb[3] = in_data.above_right_index;
    for (int c = 0; c < MAX_COLORS; c++) begin
      score[c] = '0;
      for (int i = 0; i < pcc_pkg::NB_COUNT; i++) begin
        if (use_nb[i] && (nb[i] == pcc_pkg::IDX_W'(c))) begin
          score[c] = score[c] + pcc_pkg::NB_WEIGHT[i];
        end
      end
    end
    if (in_data.color_count > pcc_pkg::PSIZE_W'(MAX_COLORS)) begin
      n_bound = pcc_pkg::PSIZE_W'(MAX_COLORS);
    end else begin
      n_bound = in_data.color_count;
    end
  end

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign push_data = {n_bound, score};

endmodule

`default_nettype wire

### hw/rtl/pcc_queue.sv
// ----------------------------------------------------------------------------
// pcc_queue: two-entry queue between front and back
// Lets the front keep accepting while the back is held by a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_queue #(
  parameter int QW = 36
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  wire [QW-1:0]   push_data,
  input  wire            pop,
  output logic           full,
  output logic           head_valid,
  output logic [QW-1:0]  head_data
);

  logic [QW-1:0] mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  assign full       = count[1];
  assign head_valid = |count;
  assign head_data  = mem[rp];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> full)
    else $error("queue lost an entry while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

### hw/rtl/pcc_back.sv
// ----------------------------------------------------------------------------
// pcc_back: ranking passes, base-11 packing and context match
// Four selection stages, one pass each, then a pack stage and the output
// register. Each stage moves forward when the one after it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_back #(
  parameter int MAX_COLORS = 8,
  parameter int QW         = pcc_pkg::PSIZE_W + MAX_COLORS * pcc_pkg::SCORE_W
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                head_valid,
  input  wire [QW-1:0]       head_data,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_stall,
  output pcc_pkg::out_t      out_data
);

  localparam int NPASS = 4;

  typedef logic [MAX_COLORS-1:0][pcc_pkg::SCORE_W-1:0] score_vec_t;

  // pass stage registers
  score_vec_t                  sc_q   [NPASS];
  pcc_pkg::order_t             ord_q  [NPASS];
  logic [pcc_pkg::PSIZE_W-1:0] n_q    [NPASS];
  logic [NPASS-1:0]            v_pass;

  // pass stage inputs and results
  score_vec_t                  sc_in  [NPASS];
  pcc_pkg::order_t             ord_in [NPASS];
  logic [pcc_pkg::PSIZE_W-1:0] n_in   [NPASS];
  logic [NPASS-1:0]            v_in;
  score_vec_t                  sc_nx  [NPASS];
  pcc_pkg::order_t             ord_nx [NPASS];
  logic [NPASS-1:0]            en_pass;

  // pack stage and output registers
  logic [pcc_pkg::CTX_W-1:0]   packed_q;
  pcc_pkg::order_t             ord_pack;
  logic                        v_pack;
  logic [pcc_pkg::CTX_W-1:0]   ctx_o;
  pcc_pkg::order_t             ord_o;
  logic [pcc_pkg::CTX_W-1:0]   packed_next;
  logic [pcc_pkg::CTX_W-1:0]   ctx_next;
  logic                        en_pack;
  logic                        en_out;
  pcc_pkg::order_t             ord_id;

  // enable chain from the output back to the queue head
  always_comb begin
    en_out  = !out_valid || !out_stall;
    en_pack = !v_pack || en_out;
    en_pass[NPASS-1] = !v_pass[NPASS-1] || en_pack;
    for (int k = NPASS - 2; k >= 0; k--) begin
      en_pass[k] = !v_pass[k] || en_pass[k+1];
    end
  end

  assign pop = head_valid && en_pass[0];

  always_comb begin
    for (int s = 0; s < pcc_pkg::ORDER_SLOTS; s++) begin
      ord_id[s] = pcc_pkg::IDX_W'(s);
    end
    sc_in[0]  = head_data[MAX_COLORS*pcc_pkg::SCORE_W-1:0];
    n_in[0]   = head_data[QW-1 -: pcc_pkg::PSIZE_W];
    ord_in[0] = ord_id;
    v_in[0]   = head_valid;
    for (int k = 1; k < NPASS; k++) begin
      sc_in[k]  = sc_q[k-1];
      n_in[k]   = n_q[k-1];
      ord_in[k] = ord_q[k-1];
      v_in[k]   = v_pass[k-1];
    end
  end

  for (genvar k = 0; k < NPASS; k++) begin : g_pass
    logic [pcc_pkg::SCORE_W-1:0] best;
    logic [MAX_COLORS-1:0]       hit;

    // pick the highest score among later positions below the bound;
    // a tie keeps the earlier position
    always_comb begin
      best = sc_in[k][k];
      hit  = '0;
      for (int j = k + 1; j < MAX_COLORS; j++) begin
        if ((pcc_pkg::PSIZE_W'(j) < n_in[k]) && (sc_in[k][j] > best)) begin
          best = sc_in[k][j];
          hit  = '0;
          hit[j] = 1'b1;
        end
      end
      sc_nx[k]  = sc_in[k];
      ord_nx[k] = ord_in[k];
      if (|hit) begin
        sc_nx[k][k]  = best;
        ord_nx[k][k] = '0;
        for (int j = k + 1; j < MAX_COLORS; j++) begin
          if (hit[j]) begin
            sc_nx[k][j]  = sc_in[k][k];
            ord_nx[k][j] = ord_in[k][k];
            ord_nx[k][k] = ord_in[k][j];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_pass[k] <= 1'b0;
      end else if (en_pass[k]) begin
        v_pass[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en_pass[k]) begin
        sc_q[k]  <= sc_nx[k];
        ord_q[k] <= ord_nx[k];
        n_q[k]   <= n_in[k];
      end
    end
  end

  // base-11 packing of the four leading scores
  always_comb begin
    packed_next = pcc_pkg::CTX_W'(sc_q[NPASS-1][0]);
    for (int i = 1; i < NPASS; i++) begin
      packed_next = pcc_pkg::CTX_W'(packed_next * pcc_pkg::PACK_BASE)
                  + pcc_pkg::CTX_W'(sc_q[NPASS-1][i]);
    end
  end

  // table entries are distinct, so at most one matches
  always_comb begin
    ctx_next = packed_q;
    for (int i = 0; i < pcc_pkg::CONTEXT_COUNT; i++) begin
      if (packed_q == pcc_pkg::CTX_TABLE[i]) begin
        ctx_next = pcc_pkg::CTX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pack    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_pack) begin
        v_pack <= v_pass[NPASS-1];
      end
      if (en_out) begin
        out_valid <= v_pack;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_pack) begin
      packed_q <= packed_next;
      ord_pack <= ord_q[NPASS-1];
    end
    if (en_out) begin
      ctx_o <= ctx_next;
      ord_o <= ord_pack;
    end
  end

  always_comb begin
    out_data.color_context = ctx_o;
    out_data.order_0       = ord_o[0];
    out_data.order_1       = ord_o[1];
    out_data.order_2       = ord_o[2];
    out_data.order_3       = ord_o[3];
    out_data.order_4       = ord_o[4];
    out_data.order_5       = ord_o[5];
    out_data.order_6       = ord_o[6];
    out_data.order_7       = ord_o[7];
  end

  // checks: the order stays a permutation, raw contexts match no table entry
  logic [pcc_pkg::ORDER_SLOTS-1:0] perm_mask;
  logic                            raw_hit;

  always_comb begin
    perm_mask = '0;
    for (int s = 0; s < pcc_pkg::ORDER_SLOTS; s++) begin
      perm_mask = perm_mask | (pcc_pkg::ORDER_SLOTS'(1) << ord_o[s]);
    end
    raw_hit = 1'b0;
    for (int i = 0; i < pcc_pkg::CONTEXT_COUNT; i++) begin
      raw_hit = raw_hit || (ctx_o == pcc_pkg::CTX_TABLE[i]);
    end
  end

  a_order_perm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (perm_mask == '1))
    else $error("color order is not a permutation");

  a_ctx_raw: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ctx_o >= pcc_pkg::CTX_W'(pcc_pkg::CONTEXT_COUNT)) |-> !raw_hit)
    else $error("raw context value should have matched the table");

  a_pack_bound: assert property (@(posedge clk) disable iff (rst)
    v_pack |-> (packed_q <= pcc_pkg::PACK_MAX))
    else $error("packed score value out of range");

endmodule

`default_nettype wire

### hw/rtl/palette_color_context_core.sv
// ----------------------------------------------------------------------------
// palette_color_context_core: palette color index context for one pixel
// Scores the four neighbor indices, ranks them and derives the context.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall is low and returns one result per
// pixel, in order. The front scores neighbors in the accept cycle and writes a
// two-entry queue; the back runs four selection stages (one pass each), a
// packing stage and the output register. Sustained rate is one item per cycle
// while the output is not stalled, bounded by the single queue write and pop
// per cycle. A stalled output holds the back; the queue absorbs two more
// items before in_stall rises.
`default_nettype none

module palette_color_context_core #(
  parameter int MAX_COLORS = 8
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire pcc_pkg::in_t in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output pcc_pkg::out_t     out_data
);

  localparam int QW = pcc_pkg::PSIZE_W + MAX_COLORS * pcc_pkg::SCORE_W;

  logic          push;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          head_valid;
  logic [QW-1:0] head_data;
  logic          pop;

  pcc_front #(
    .MAX_COLORS (MAX_COLORS),
    .QW         (QW)
  ) u_front (
    .in_data   (in_data),
    .in_valid  (in_valid),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_data (push_data)
  );

  pcc_queue #(
    .QW (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  pcc_back #(
    .MAX_COLORS (MAX_COLORS),
    .QW         (QW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

### tb/palette_color_context_core_test.sv
// ----------------------------------------------------------------------------
// palette_color_context_core_test: self-checking bench for the context core
// Drives pixels with neighbor indices through the input channel, predicts
// the color context and color order per pixel, and checks every result in
// order while in some tests the sender idles and the output stalls at random.
// ----------------------------------------------------------------------------
module palette_color_context_core_test;

  localparam int PALETTE_MAX = 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 12;

  localparam int NEIGHBOR_WEIGHT [4] = '{3, 2, 3, 2};
  localparam int KNOWN_PATTERNS [16] = '{
    3993, 4235, 4378, 4380, 5720, 6655, 7018, 7040,
    7260, 8228, 8250, 8470, 9680, 10648, 10890, 13310
  };

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  pcc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  pcc_pkg::out_t out_data;

  pcc_pkg::out_t expected_contexts [$];
  int   error_count = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  int   stall_mode = 0;     // 0: never stall, 1: mixed, 2: mostly stalled
  bit   sender_gaps = 1'b0;

  palette_color_context_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Score the kept neighbors, run the four selection passes, pack the
  // leading scores in base 11 and look the pattern up.
  function automatic pcc_pkg::out_t predict_context(pcc_pkg::in_t px);
    int   score [PALETTE_MAX];
    int   color [PALETTE_MAX];
    int   nb [4];
    bit   keep [4];
    int   bound, best, best_pos, swap_val, packed_val, ctx;
    pcc_pkg::out_t res;
    bound = (px.color_count > PALETTE_MAX) ? PALETTE_MAX : int'(px.color_count);
    nb[0] = px.left_index;
    nb[1] = px.above_left_index;
    nb[2] = px.above_index;
    nb[3] = px.above_right_index;
    keep[0] = px.col != 0;
    keep[1] = px.col != 0 && px.row != 0;
    keep[2] = px.row != 0;
    keep[3] = px.row != 0 && px.block_width >= 1 &&
              int'(px.col) + 1 <= int'(px.block_width) - 1;
    for (int i = 0; i < PALETTE_MAX; i++) begin
      score[i] = 0;
      color[i] = i;
    end
    for (int i = 0; i < 4; i++) begin
      if (keep[i] && nb[i] < PALETTE_MAX) score[nb[i]] += NEIGHBOR_WEIGHT[i];
    end
    for (int i = 0; i < 4; i++) begin
      best = score[i];
      best_pos = i;
      for (int j = i + 1; j < bound; j++) begin
        if (score[j] > best) begin
          best = score[j];
          best_pos = j;
        end
      end
      if (best_pos != i) begin
        swap_val = score[i];
        score[i] = score[best_pos];
        score[best_pos] = swap_val;
        swap_val = color[i];
        color[i] = color[best_pos];
        color[best_pos] = swap_val;
      end
    end
    packed_val = 0;
    for (int i = 0; i < 4; i++) packed_val = packed_val * 11 + score[i];
    ctx = packed_val;
    for (int i = 15; i >= 0; i--) begin
      if (packed_val == KNOWN_PATTERNS[i]) ctx = i;
    end
    res.color_context = pcc_pkg::CTX_W'(ctx);
    res.order_0 = pcc_pkg::IDX_W'(color[0]);
    res.order_1 = pcc_pkg::IDX_W'(color[1]);
    res.order_2 = pcc_pkg::IDX_W'(color[2]);
    res.order_3 = pcc_pkg::IDX_W'(color[3]);
    res.order_4 = pcc_pkg::IDX_W'(color[4]);
    res.order_5 = pcc_pkg::IDX_W'(color[5]);
    res.order_6 = pcc_pkg::IDX_W'(color[6]);
    res.order_7 = pcc_pkg::IDX_W'(color[7]);
    return res;
  endfunction

  function automatic logic [pcc_pkg::IDX_W-1:0] order_slot(pcc_pkg::out_t r, int k);
    return r[(pcc_pkg::ORDER_SLOTS - 1 - k) * pcc_pkg::IDX_W +: pcc_pkg::IDX_W];
  endfunction

  function automatic pcc_pkg::in_t make_pixel(int l, int al, int a, int ar, int r,
                                              int c, int w, int ps);
    pcc_pkg::in_t px;
    px.left_index        = pcc_pkg::IDX_W'(l);
    px.above_left_index  = pcc_pkg::IDX_W'(al);
    px.above_index       = pcc_pkg::IDX_W'(a);
    px.above_right_index = pcc_pkg::IDX_W'(ar);
    px.row               = pcc_pkg::POS_W'(r);
    px.col               = pcc_pkg::POS_W'(c);
    px.block_width       = pcc_pkg::WIDTH_W'(w);
    px.color_count       = pcc_pkg::PSIZE_W'(ps);
    return px;
  endfunction

  // Mostly legal pixels inside the block with small palettes, so that the
  // known patterns come up; the rest is raw noise over every bit.
  function automatic pcc_pkg::in_t random_pixel();
    int ps, w, r, c;
    if ($urandom_range(0, 99) < 85) begin
      ps = $urandom_range(0, 1) ? $urandom_range(2, 4) : $urandom_range(1, 8);
      w  = $urandom_range(1, 64);
      c  = $urandom_range(0, 3) == 0 ? w - 1 : $urandom_range(0, w - 1);
      r  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 63);
      return make_pixel($urandom_range(0, ps - 1), $urandom_range(0, ps - 1),
                        $urandom_range(0, ps - 1), $urandom_range(0, ps - 1),
                        r, c, w, ps);
    end
    return make_pixel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
  endfunction

  function automatic int gap_length();
    int r;
    if (!sender_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one pixel and hold it until the transfer; valid stays high when
  // the next pixel follows without a gap.
  task automatic send_pixel(input pcc_pkg::in_t px);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_contexts.push_back(predict_context(px));
    @(negedge clk);
  endtask

  task automatic test_directed();
    sender_gaps = 1'b0;
    stall_mode  = 0;
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 8, 8));     // origin: no neighbors
    send_pixel(make_pixel(1, 2, 3, 4, 0, 5, 8, 8));     // top row: left only
    send_pixel(make_pixel(5, 5, 5, 5, 3, 3, 8, 8));     // one color everywhere
    send_pixel(make_pixel(7, 7, 7, 7, 63, 63, 127, 8)); // index, position and width maxima
    send_pixel(make_pixel(7, 6, 7, 6, 2, 2, 8, 2));     // indices past palette
    send_pixel(make_pixel(1, 0, 1, 0, 2, 2, 8, 0));     // empty palette
    send_pixel(make_pixel(3, 3, 1, 1, 2, 2, 8, 1));     // single color palette
    send_pixel(make_pixel(6, 7, 6, 5, 2, 2, 8, 9));     // palette size saturates
    send_pixel(make_pixel(4, 7, 5, 7, 9, 9, 16, 15));
    send_pixel(make_pixel(0, 1, 2, 3, 4, 4, 0, 8));     // zero block width
    send_pixel(make_pixel(1, 2, 3, 4, 4, 10, 8, 8));    // column past width
    send_pixel(make_pixel(1, 2, 3, 4, 4, 7, 8, 8));     // last column
    send_pixel(make_pixel(1, 2, 3, 4, 4, 0, 8, 8));     // first column
    send_pixel(make_pixel(1, 2, 3, 4, 4, 4, 8, 8));     // tied scores
    send_pixel(make_pixel(2, 3, 2, 3, 4, 4, 8, 8));
    send_pixel(make_pixel(0, 5, 0, 5, 1, 63, 64, 8));
    send_pixel(make_pixel(2, 2, 2, 2, 5, 0, 1, 3));
    send_pixel(make_pixel(0, 0, 3, 3, 1, 1, 16, 4));
    send_pixel(make_pixel(6, 1, 6, 1, 10, 10, 64, 4));  // winners past palette
    send_pixel(make_pixel(3, 2, 1, 0, 1, 1, 32, 5));
    send_pixel(make_pixel(0, 1, 0, 1, 1, 1, 3, 2));
  endtask

  task automatic test_random_flow(input int count);
    sender_gaps = 1'b1;
    stall_mode  = 1;
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic test_back_to_back(input int count);
    sender_gaps = 1'b0;
    stall_mode  = 0;
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic test_output_pressure(input int count);
    sender_gaps = 1'b0;
    stall_mode  = 2;
    repeat (count) send_pixel(random_pixel());
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          out_stall  <= 1'b0;
          stall_left <= (stall_mode == 2) ? 0 : $urandom_range(0, 8);
        end
        9: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(10, 30);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    pcc_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_contexts.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_contexts.pop_front();
        if (out_data.color_context !== want.color_context) begin
          $display("%0t: color_context expected %0d actual %0d", $time,
                   want.color_context, out_data.color_context);
          error_count++;
        end
        for (int k = 0; k < pcc_pkg::ORDER_SLOTS; k++) begin
          if (order_slot(out_data, k) !== order_slot(want, k)) begin
            $display("%0t: order_%0d expected %0d actual %0d", $time, k,
                     order_slot(want, k), order_slot(out_data, k));
            error_count++;
          end
        end
      end
    end
  end

  // End the run when neither channel makes a transfer for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_flow(350);
    test_back_to_back(170);
    test_output_pressure(180);
    in_valid = 1'b0;
    while (expected_contexts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
